// ===== hdl/adsr_gain_envelope_generator_macros.svh =====
// assertion macros shared by the rate modulo and the top-level module
`ifndef ADSR_GAIN_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_GAIN_ENVELOPE_GENERATOR_MACROS_SVH

// property checked at every clock edge outside reset
`define ADSR_EG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define ADSR_EG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/adsr_eg_pkg.sv =====
// types, constants and rate tables of the envelope generator
package adsr_eg_pkg;

  localparam int unsigned LevelW = 12;
  localparam int unsigned CntW   = 15;
  localparam int unsigned PerW   = 16;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned OffW   = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CntW-1:0]   CounterTop = 15'd30720;
  localparam logic [LevelW:0]   LevelMax   = 13'h7ff;
  localparam logic [LevelW:0]   BendPoint  = 13'h600;

  typedef enum logic [1:0] {
    PH_ATTACK,
    PH_DECAY,
    PH_SUSTAIN,
    PH_RELEASE
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WRITE
  } state_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ADSR_MODE,
    REG_ATTACK_RATE,
    REG_DECAY_RATE,
    REG_SUSTAIN_LEVEL,
    REG_SUSTAIN_RATE,
    REG_GAIN_SETTING
  } reg_idx_e;

  typedef enum logic [1:0] {
    GC_LIN_DOWN,
    GC_EXP_DOWN,
    GC_LIN_UP,
    GC_BENT_UP
  } gain_curve_e;

  typedef struct packed {
    logic       adsr_mode;
    logic [3:0] attack_rate;
    logic [2:0] decay_rate;
    logic [2:0] sustain_level;
    logic [4:0] sustain_rate;
    logic [7:0] gain_setting;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    phase_e            phase;
    logic              active;
    logic              start_pend;
    logic              rel_pend;
  } env_t;

  // period of each rate index, in sample ticks
  function automatic logic [PerW-1:0] period_of(input logic [IdxW-1:0] idx);
    logic [PerW-1:0] p;
    unique case (idx)
      5'd0:  p = 16'd65535;
      5'd1:  p = 16'd2048;
      5'd2:  p = 16'd1536;
      5'd3:  p = 16'd1280;
      5'd4:  p = 16'd1024;
      5'd5:  p = 16'd768;
      5'd6:  p = 16'd640;
      5'd7:  p = 16'd512;
      5'd8:  p = 16'd384;
      5'd9:  p = 16'd320;
      5'd10: p = 16'd256;
      5'd11: p = 16'd192;
      5'd12: p = 16'd160;
      5'd13: p = 16'd128;
      5'd14: p = 16'd96;
      5'd15: p = 16'd80;
      5'd16: p = 16'd64;
      5'd17: p = 16'd48;
      5'd18: p = 16'd40;
      5'd19: p = 16'd32;
      5'd20: p = 16'd24;
      5'd21: p = 16'd20;
      5'd22: p = 16'd16;
      5'd23: p = 16'd12;
      5'd24: p = 16'd10;
      5'd25: p = 16'd8;
      5'd26: p = 16'd6;
      5'd27: p = 16'd5;
      5'd28: p = 16'd4;
      5'd29: p = 16'd3;
      5'd30: p = 16'd2;
      default: p = 16'd1;
    endcase
    return p;
  endfunction

  // phase offset by rate index modulo three
  function automatic logic [OffW-1:0] offset_of(input logic [IdxW-1:0] idx);
    logic [OffW-1:0] o;
    unique case (idx)
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27,
      5'd30: o = 11'd536;
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28,
      5'd31: o = 11'd0;
      default: o = 11'd1040;
    endcase
    return o;
  endfunction

endpackage

// ===== hdl/adsr_eg_rate_div.sv =====
// bit-serial restoring modulo that decides whether a rate tick fires
`include "adsr_gain_envelope_generator_macros.svh"

module adsr_eg_rate_div
  import adsr_eg_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [CntW-1:0] dividend_i,
  input  logic [PerW-1:0] divisor_i,
  output logic            done_o,
  output logic            zero_o
);

  localparam int unsigned StepW = $clog2(CntW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  dvd_q, dvd_d;
  logic [PerW-1:0]  dvs_q, dvs_d;
  logic [PerW-1:0]  rem_q, rem_d;
  logic [PerW:0]    trial;
  logic [PerW:0]    diff;

  // on start the operands load; while busy, one dividend bit enters the partial remainder per cycle
  always_comb begin
    trial  = {rem_q, dvd_q[CntW-1]};
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(CntW - 1);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[CntW-2:0], 1'b0};
      rem_d = diff[PerW] ? trial[PerW-1:0] : diff[PerW-1:0];
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == '0);

  `ADSR_EG_ASSERT(a_rem_below_divisor, busy_q |-> (rem_q < dvs_q), "remainder not reduced")
  `ADSR_EG_ASSERT(a_done_not_busy, done_q |-> !busy_q, "done while still stepping")
  `ADSR_EG_ASSERT_NEXT(a_start_busy, start_i, busy_q, "start did not begin stepping")

endmodule

// ===== hdl/adsr_eg_level_upd.sv =====
// next envelope state for one tick and the rate index that tick uses
module adsr_eg_level_upd
  import adsr_eg_pkg::*;
(
  input  cfg_t            cfg_i,
  input  env_t            env_i,
  input  logic            voice_end_i,
  input  logic            fires_i,
  output logic [IdxW-1:0] rate_idx_o,
  output env_t            env_o
);

  logic [LevelW:0] lvl;
  logic [LevelW:0] bound;
  logic            work;

  function automatic logic [LevelW:0] exp_down(input logic [LevelW:0] e);
    logic [LevelW:0] em1;
    em1 = e - 1'b1;
    return (e == '0) ? '0 : (em1 - (em1 >> 8));
  endfunction

  // release first, then start, then the selected curve
  always_comb begin
    env_o      = env_i;
    lvl        = {1'b0, env_i.level};
    bound      = {1'b0, 4'(env_i.level[0] & 1'b0) + 4'(cfg_i.sustain_level) + 4'd1, 8'd0};
    work       = env_i.active | env_i.start_pend;
    rate_idx_o = cfg_i.gain_setting[IdxW-1:0];
    if (work) begin
      if (env_i.rel_pend) begin
        env_o.rel_pend = 1'b0;
        env_o.phase    = PH_RELEASE;
      end else begin
        if (env_i.start_pend) begin
          env_o.start_pend = 1'b0;
          lvl              = '0;
          env_o.phase      = PH_ATTACK;
          env_o.active     = 1'b1;
        end
        if (cfg_i.adsr_mode) begin
          unique case (env_o.phase)
            PH_ATTACK: begin
              rate_idx_o = {cfg_i.attack_rate, 1'b1};
              if (fires_i) begin
                lvl = lvl + ((cfg_i.attack_rate == 4'd15) ? 13'd1024 : 13'd32);
                if (lvl >= LevelMax) begin
                  lvl         = LevelMax;
                  env_o.phase = PH_DECAY;
                end
              end
            end
            PH_DECAY: begin
              rate_idx_o = {1'b1, cfg_i.decay_rate, 1'b0};
              if (fires_i) begin
                lvl = exp_down(lvl);
                if (lvl <= bound) begin
                  lvl         = bound;
                  env_o.phase = PH_SUSTAIN;
                end
              end
            end
            PH_SUSTAIN: begin
              rate_idx_o = cfg_i.sustain_rate;
              if ((cfg_i.sustain_rate != '0) && fires_i) begin
                lvl = exp_down(lvl);
              end
            end
            default: begin
              rate_idx_o = '0;
              if (lvl < 13'd8) begin
                lvl          = '0;
                env_o.active = 1'b0;
              end else begin
                lvl = lvl - 13'd8;
              end
            end
          endcase
        end else if (cfg_i.gain_setting[7]) begin
          // direct level
          lvl = {2'b00, cfg_i.gain_setting[6:0], 4'd0};
        end else if ((cfg_i.gain_setting[4:0] != '0) && fires_i) begin
          unique case (gain_curve_e'(cfg_i.gain_setting[6:5]))
            GC_LIN_DOWN: lvl = (lvl < 13'd32) ? '0 : (lvl - 13'd32);
            GC_EXP_DOWN: lvl = exp_down(lvl);
            GC_LIN_UP: begin
              lvl = lvl + 13'd32;
              if (lvl > LevelMax) lvl = LevelMax;
            end
            default: begin
              lvl = lvl + ((lvl < BendPoint) ? 13'd32 : 13'd8);
              if (lvl > LevelMax) lvl = LevelMax;
            end
          endcase
        end
        if (voice_end_i) begin
          env_o.active = 1'b0;
        end
      end
    end
    env_o.level = lvl[LevelW-1:0];
  end

endmodule

// ===== hdl/adsr_gain_envelope_generator.sv =====
// top level of the one-voice adsr and gain envelope generator
// an accepted word runs the 15-step bit-serial rate modulo in the calc state and is committed to
// the result register from the write state once it is free; only the idle state takes a new word
// the result register frees the slave side while a finished word waits to be taken
// reset: asynchronous, active low; level, phase, flags and rate counter clear to zero
module adsr_gain_envelope_generator
  import adsr_eg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // key_on, key_off, voice_end
  // master side
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // envelope_level, envelope_readout,
                                             // voice_active, phase
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  `include "adsr_gain_envelope_generator_macros.svh"

  state_e            state_q, state_d;
  cfg_t              cfg_q;
  logic [LevelW-1:0] level_q;
  phase_e            phase_q;
  logic              active_q;
  logic              start_pend_q;
  logic              rel_pend_q;
  logic              vend_q;
  logic [CntW-1:0]   rate_cnt_q;
  logic              m_valid_q;
  logic [23:0]       m_data_q;

  logic              accept;
  logic              commit;
  logic              out_free;
  logic              div_start;
  logic              div_done;
  logic              div_zero;
  logic [IdxW-1:0]   rate_idx;
  logic [CntW-1:0]   dividend;
  env_t              env_cur;
  env_t              env_nxt;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign out_free = ~m_valid_q | m_axis_tready;

  // current state with this word's key requests folded in
  always_comb begin
    env_cur.level      = level_q;
    env_cur.phase      = phase_q;
    env_cur.active     = active_q;
    env_cur.start_pend = start_pend_q | (accept & s_axis_tdata[0]);
    env_cur.rel_pend   = rel_pend_q | (accept & s_axis_tdata[1]);
  end

  adsr_eg_level_upd u_level_upd (
    .cfg_i       (cfg_q),
    .env_i       (env_cur),
    .voice_end_i (vend_q),
    .fires_i     (div_zero),
    .rate_idx_o  (rate_idx),
    .env_o       (env_nxt)
  );

  // shared counter plus the phase offset of the selected rate
  assign dividend = rate_cnt_q + CntW'(offset_of(rate_idx));

  adsr_eg_rate_div u_rate_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (period_of(rate_idx)),
    .done_o     (div_done),
    .zero_o     (div_zero)
  );

  // sequencer next state and strobes
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    commit        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          div_start = 1'b1;
          state_d   = ST_CALC;
        end
      end
      ST_CALC: begin
        if (div_done) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ADSR_MODE:     cfg_q.adsr_mode     <= cfg_data_i[0];
        REG_ATTACK_RATE:   cfg_q.attack_rate   <= cfg_data_i[3:0];
        REG_DECAY_RATE:    cfg_q.decay_rate    <= cfg_data_i[2:0];
        REG_SUSTAIN_LEVEL: cfg_q.sustain_level <= cfg_data_i[2:0];
        REG_SUSTAIN_RATE:  cfg_q.sustain_rate  <= cfg_data_i[4:0];
        REG_GAIN_SETTING:  cfg_q.gain_setting  <= cfg_data_i;
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  // envelope state, pending requests and rate counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= '0;
      phase_q      <= PH_ATTACK;
      active_q     <= 1'b0;
      start_pend_q <= 1'b0;
      rel_pend_q   <= 1'b0;
      vend_q       <= 1'b0;
      rate_cnt_q   <= '0;
    end else if (accept) begin
      start_pend_q <= env_cur.start_pend;
      rel_pend_q   <= env_cur.rel_pend;
      vend_q       <= s_axis_tdata[2];
    end else if (commit) begin
      level_q      <= env_nxt.level;
      phase_q      <= env_nxt.phase;
      active_q     <= env_nxt.active;
      start_pend_q <= env_nxt.start_pend;
      rel_pend_q   <= env_nxt.rel_pend;
      rate_cnt_q   <= (rate_cnt_q == '0) ? CounterTop : (rate_cnt_q - 1'b1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (commit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      m_data_q <= {1'b0, env_nxt.phase, env_nxt.active,
                   env_nxt.level[LevelW-1:4], env_nxt.level};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `ADSR_EG_ASSERT(a_level_range, m_axis_tvalid |-> (m_axis_tdata[11:0] <= 12'd2048), "level out of range")
  `ADSR_EG_ASSERT(a_counter_range, rate_cnt_q <= CounterTop, "rate counter beyond top")
  `ADSR_EG_ASSERT(a_done_in_calc, div_done |-> (state_q == ST_CALC), "modulo finished outside calc")
  `ADSR_EG_ASSERT_NEXT(a_commit_shows, commit, m_axis_tvalid, "committed word not presented")

endmodule
